@@ design/v3n_pkg.sv @@
// ----------------------------------------------------------------------------
// v3n_pkg
// Types and constants shared by the vector normalize pipeline.
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int SQ_W       = 2 * COMP_WIDTH;
  localparam int S4_W       = SQ_W + 2;

  // quotients are floor(num * 2^50 / s), num <= s
  localparam int DIV_QW     = 51;
  localparam int UNIT_SHIFT = 20;

  localparam int SQRT_W  = (S4_W > DIV_QW + 1) ? S4_W : DIV_QW + 1;
  localparam int SQRT_RW = SQRT_W / 2;

  localparam logic [15:0] LEN_MAX  = 16'hFFFF;
  localparam logic [24:0] INV_MAX  = 25'h1000000;
  localparam logic [15:0] UNIT_MAX = 16'd16384;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] comp_x;
    logic signed [COMP_WIDTH-1:0] comp_y;
    logic signed [COMP_WIDTH-1:0] comp_z;
  } in_t;

  typedef struct packed {
    logic [15:0]        length;
    logic [24:0]        inv_length;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic               zero_vector;
  } out_t;

  // per-item flags that ride alongside the arithmetic
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

endpackage

@@ design/vector3_normalize_unit.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// Magnitude, inverse magnitude and unit vector of a signed Q8.8 3-vector.
// ----------------------------------------------------------------------------
// One request is taken per clock while the output side keeps up; each result
// passes through 3 front stages, 51 divider stages at one quotient bit each,
// 26 square root stages at one root bit each, and the output register.
// Latency is set by the bit-per-stage divider and root pipelines. When a
// result waits at the output the whole pipeline holds, and a new request
// is taken in the same cycle the waiting result is taken.
// A zero vector raises zero_vector with all other fields zero.
module vector3_normalize_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  v3n_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output v3n_pkg::out_t out_data
);

  localparam int SW    = v3n_pkg::SQ_W;
  localparam int S4W   = v3n_pkg::S4_W;
  localparam int QW    = v3n_pkg::DIV_QW;
  localparam int XW    = v3n_pkg::SQRT_W;
  localparam int RW    = v3n_pkg::SQRT_RW;
  localparam int SIDEW = $bits(v3n_pkg::side_t);
  localparam int LAT   = 3 + QW + RW;

  logic adv;

  logic [SW-1:0]  sq_x, sq_y, sq_z, den;
  logic [S4W-1:0] s4, s4_d;
  v3n_pkg::side_t side_f, side_d1, side_d2;

  logic [QW-1:0] q_inv, q_x, q_y, q_z;
  logic [RW-1:0] rt_len, rt_inv, rt_x, rt_y, rt_z;

  logic [LAT-1:0] vld_r;
  logic           out_valid_r;
  v3n_pkg::out_t  out_data_r, out_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  v3n_front u_front (
    .clk(clk), .en(adv), .in_data(in_data),
    .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z), .den(den), .s4(s4), .side(side_f)
  );

  v3n_div #(.DW(SW), .QW(QW)) u_div_inv (
    .clk(clk), .en(adv), .num(SW'(1)), .den(den), .quo(q_inv));
  v3n_div #(.DW(SW), .QW(QW)) u_div_x (
    .clk(clk), .en(adv), .num(sq_x), .den(den), .quo(q_x));
  v3n_div #(.DW(SW), .QW(QW)) u_div_y (
    .clk(clk), .en(adv), .num(sq_y), .den(den), .quo(q_y));
  v3n_div #(.DW(SW), .QW(QW)) u_div_z (
    .clk(clk), .en(adv), .num(sq_z), .den(den), .quo(q_z));

  v3n_delay #(.WIDTH(S4W + SIDEW), .DEPTH(QW)) u_dly_div (
    .clk(clk), .en(adv), .din({s4, side_f}), .dout({s4_d, side_d1}));

  // unit quotients carry 2^50 scaling; drop to 2^30 before the root
  v3n_sqrt #(.XW(XW)) u_sqrt_len (
    .clk(clk), .en(adv), .x(XW'(s4_d)), .root(rt_len));
  v3n_sqrt #(.XW(XW)) u_sqrt_inv (
    .clk(clk), .en(adv), .x(XW'(q_inv)), .root(rt_inv));
  v3n_sqrt #(.XW(XW)) u_sqrt_x (
    .clk(clk), .en(adv), .x(XW'(q_x[QW-1:v3n_pkg::UNIT_SHIFT])), .root(rt_x));
  v3n_sqrt #(.XW(XW)) u_sqrt_y (
    .clk(clk), .en(adv), .x(XW'(q_y[QW-1:v3n_pkg::UNIT_SHIFT])), .root(rt_y));
  v3n_sqrt #(.XW(XW)) u_sqrt_z (
    .clk(clk), .en(adv), .x(XW'(q_z[QW-1:v3n_pkg::UNIT_SHIFT])), .root(rt_z));

  v3n_delay #(.WIDTH(SIDEW), .DEPTH(RW)) u_dly_sqrt (
    .clk(clk), .en(adv), .din(side_d1), .dout(side_d2));

  // round half up of a doubled-scale root
  function automatic logic [RW:0] half_round(logic [RW-1:0] r);
    logic [RW:0] t;
    t = {1'b0, r} + 1'b1;
    return t >> 1;
  endfunction

  function automatic logic [15:0] unit_code(logic [RW-1:0] r, logic neg);
    logic [RW:0] u;
    logic [15:0] m;
    u = half_round(r);
    m = (u > (RW+1)'(v3n_pkg::UNIT_MAX)) ? v3n_pkg::UNIT_MAX : u[15:0];
    return neg ? 16'(~m + 1'b1) : m;
  endfunction

  always_comb begin
    logic [RW:0] lr, ir;
    lr = half_round(rt_len);
    ir = half_round(rt_inv);
    out_nxt.length      = (lr > (RW+1)'(v3n_pkg::LEN_MAX)) ? v3n_pkg::LEN_MAX : lr[15:0];
    out_nxt.inv_length  = (ir > (RW+1)'(v3n_pkg::INV_MAX)) ? v3n_pkg::INV_MAX : ir[24:0];
    out_nxt.unit_x      = unit_code(rt_x, side_d2.neg[2]);
    out_nxt.unit_y      = unit_code(rt_y, side_d2.neg[1]);
    out_nxt.unit_z      = unit_code(rt_z, side_d2.neg[0]);
    out_nxt.zero_vector = 1'b0;
    if (side_d2.zero) begin
      out_nxt             = '0;
      out_nxt.zero_vector = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_vector |->
      out_data.length == '0 && out_data.inv_length == '0 &&
      out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0)
    else $error("zero vector result carries nonzero fields");

  a_nonzero_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.zero_vector |->
      out_data.length != '0 && out_data.inv_length != '0 &&
      out_data.inv_length <= v3n_pkg::INV_MAX)
    else $error("nonzero vector gives bad magnitude");

  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.unit_x >= -16'sd16384 && out_data.unit_x <= 16'sd16384 &&
      out_data.unit_y >= -16'sd16384 && out_data.unit_y <= 16'sd16384 &&
      out_data.unit_z >= -16'sd16384 && out_data.unit_z <= 16'sd16384)
    else $error("unit component out of range");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

@@ design/v3n_front.sv @@
// ----------------------------------------------------------------------------
// v3n_front
// Three stages: component magnitudes, squares, sum of squares.
// ----------------------------------------------------------------------------
module v3n_front (
  input  logic                           clk,
  input  logic                           en,
  input  v3n_pkg::in_t                   in_data,
  output logic [v3n_pkg::SQ_W-1:0]       sq_x,
  output logic [v3n_pkg::SQ_W-1:0]       sq_y,
  output logic [v3n_pkg::SQ_W-1:0]       sq_z,
  output logic [v3n_pkg::SQ_W-1:0]       den,
  output logic [v3n_pkg::S4_W-1:0]       s4,
  output v3n_pkg::side_t                 side
);

  localparam int W  = v3n_pkg::COMP_WIDTH;
  localparam int SW = v3n_pkg::SQ_W;

  logic [W-1:0]   ax_nxt, ay_nxt, az_nxt;
  logic [W-1:0]   ax_r, ay_r, az_r;
  v3n_pkg::side_t side1_nxt, side1_r, side2_r, side3_r;
  logic [SW-1:0]  sqx_r, sqy_r, sqz_r;
  logic [SW-1:0]  sqx2_r, sqy2_r, sqz2_r;
  logic [SW-1:0]  sum_nxt, den_nxt, den_r, sum_r;

  always_comb begin
    side1_nxt.neg  = {in_data.comp_x[W-1], in_data.comp_y[W-1], in_data.comp_z[W-1]};
    // most negative code maps to 2^(W-1), still fits unsigned W bits
    ax_nxt = in_data.comp_x[W-1] ? W'(~in_data.comp_x + 1'b1) : in_data.comp_x;
    ay_nxt = in_data.comp_y[W-1] ? W'(~in_data.comp_y + 1'b1) : in_data.comp_y;
    az_nxt = in_data.comp_z[W-1] ? W'(~in_data.comp_z + 1'b1) : in_data.comp_z;
    side1_nxt.zero = (in_data.comp_x == '0) && (in_data.comp_y == '0) &&
                     (in_data.comp_z == '0);
  end

  always_comb begin
    sum_nxt = sqx_r + sqy_r + sqz_r;
    den_nxt = (sum_nxt == '0) ? SW'(1) : sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      az_r    <= az_nxt;
      side1_r <= side1_nxt;
      sqx_r   <= SW'(ax_r) * SW'(ax_r);
      sqy_r   <= SW'(ay_r) * SW'(ay_r);
      sqz_r   <= SW'(az_r) * SW'(az_r);
      side2_r <= side1_r;
      sqx2_r  <= sqx_r;
      sqy2_r  <= sqy_r;
      sqz2_r  <= sqz_r;
      sum_r   <= sum_nxt;
      den_r   <= den_nxt;
      side3_r <= side2_r;
    end
  end

  assign sq_x = sqx2_r;
  assign sq_y = sqy2_r;
  assign sq_z = sqz2_r;
  assign den  = den_r;
  assign s4   = {sum_r, 2'b00};
  assign side = side3_r;

endmodule

@@ design/v3n_div.sv @@
// ----------------------------------------------------------------------------
// v3n_div
// Pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^(QW-1) / den) for num <= den.
// ----------------------------------------------------------------------------
module v3n_div #(
  parameter int DW = v3n_pkg::SQ_W,
  parameter int QW = v3n_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] r_r [QW];
  logic [DW-1:0] d_r [QW];
  logic [QW-1:0] q_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   t;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          ge;
    logic [DW-1:0] r_nxt;

    always_comb begin
      if (k == 0) begin
        t    = {1'b0, num};
        d_in = den;
        q_in = '0;
      end else begin
        t    = {r_r[k-1], 1'b0};
        d_in = d_r[k-1];
        q_in = q_r[k-1];
      end
      ge    = (t >= {1'b0, d_in});
      r_nxt = ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= r_nxt;
        d_r[k] <= d_in;
        q_r[k] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

@@ design/v3n_sqrt.sv @@
// ----------------------------------------------------------------------------
// v3n_sqrt
// Pipelined integer square root, one root bit per stage: floor(sqrt(x)).
// ----------------------------------------------------------------------------
module v3n_sqrt #(
  parameter int XW = v3n_pkg::SQRT_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [XW-1:0]   x,
  output logic [XW/2-1:0] root
);

  localparam int RW = XW / 2;

  logic [XW-1:0] x_r    [RW];
  logic [RW+1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [XW-1:0] x_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      if (k == 0) begin
        x_in    = x;
        rem_in  = '0;
        root_in = '0;
      end else begin
        x_in    = x_r[k-1];
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
      end
      // partial remainder stays below 2^RW ahead of the last step
      cur   = {rem_in[RW-1:0], x_in[XW-1:XW-2]};
      trial = {root_in, 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= {x_in[XW-3:0], 2'b00};
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

@@ design/v3n_delay.sv @@
// ----------------------------------------------------------------------------
// v3n_delay
// Enabled shift line that keeps side data aligned with the arithmetic.
// ----------------------------------------------------------------------------
module v3n_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = v3n_pkg::DIV_QW
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks vector3_normalize_unit against a bit-exact predictor of magnitude,
// inverse magnitude and unit vector, under random idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int LATENCY = 81;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  v3n_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  v3n_pkg::out_t out_data;

  int   err_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   recv_hold;

  vector3_normalize_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // floor(sqrt(v)) on 64 bits, digit by digit
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] unit_code(input logic [63:0] mag, input bit neg,
                                            input logic [63:0] s);
    logic [63:0] u;
    u = (floor_sqrt(((mag * mag) << 30) / s) + 1) >> 1;
    if (u > 16384) u = 16384;
    return neg ? 16'(-u) : u[15:0];
  endfunction

  function automatic v3n_pkg::out_t normalize(input v3n_pkg::in_t v);
    v3n_pkg::out_t r;
    logic [63:0] ax, ay, az, s, t;
    ax = (v.comp_x < 0) ? 64'(-32'(v.comp_x)) : 64'(v.comp_x);
    ay = (v.comp_y < 0) ? 64'(-32'(v.comp_y)) : 64'(v.comp_y);
    az = (v.comp_z < 0) ? 64'(-32'(v.comp_z)) : 64'(v.comp_z);
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    s = ax * ax + ay * ay + az * az;
    t = (floor_sqrt(s << 2) + 1) >> 1;
    r.length = (t > 64'hFFFF) ? 16'hFFFF : t[15:0];
    t = (floor_sqrt((64'd1 << 50) / s) + 1) >> 1;
    r.inv_length = (t > 64'h1000000) ? v3n_pkg::INV_MAX : t[24:0];
    r.unit_x = unit_code(ax, v.comp_x < 0, s);
    r.unit_y = unit_code(ay, v.comp_y < 0, s);
    r.unit_z = unit_code(az, v.comp_z < 0, s);
    return r;
  endfunction

  class norm_scoreboard;
    v3n_pkg::out_t pending[$];

    function void note_request(v3n_pkg::in_t v);
      pending.push_back(normalize(v));
    endfunction

    task check_result(v3n_pkg::out_t got);
      v3n_pkg::out_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.length !== want.length)
        report_mismatch($sformatf("length %0d exp %0d", got.length, want.length));
      if (got.inv_length !== want.inv_length)
        report_mismatch($sformatf("inv_length %0d exp %0d", got.inv_length,
                                  want.inv_length));
      if (got.unit_x !== want.unit_x)
        report_mismatch($sformatf("unit_x %0d exp %0d", got.unit_x, want.unit_x));
      if (got.unit_y !== want.unit_y)
        report_mismatch($sformatf("unit_y %0d exp %0d", got.unit_y, want.unit_y));
      if (got.unit_z !== want.unit_z)
        report_mismatch($sformatf("unit_z %0d exp %0d", got.unit_z, want.unit_z));
      if (got.zero_vector !== want.zero_vector)
        report_mismatch($sformatf("zero_vector %0b exp %0b", got.zero_vector,
                                  want.zero_vector));
    endtask
  endclass

  norm_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: sample both channels at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // drive one request; valid stays high across back-to-back requests
  task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{comp_x: x, comp_y: y, comp_z: z};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'($signed($urandom_range(8)) - 4);
      1: return 16'(16'h8000 + $urandom_range(3));
      2: return 16'(16'h7FFF - $urandom_range(3));
      3: return 16'($urandom_range(255)) << $urandom_range(8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    pause_sender();
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) send_vector(rand_comp(), 16'd0, 16'd0);
      else send_vector(rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  initial begin
    sb            = new();
    err_count     = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, minimum magnitude, extremes, axes, mixed signs
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h0001, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'hFFFF, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h0001);
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vector(16'h8000, 16'h0000, 16'h0000);
    send_vector(16'h7FFF, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h8000, 16'h7FFF);
    send_vector(16'h0100, 16'h0100, 16'h0100);
    send_vector(16'h0300, 16'hFC00, 16'h0000);
    send_vector(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vector(16'h0001, 16'h0001, 16'h0000);
    send_vector(16'h5555, 16'hAAAA, 16'h0F0F);
    send_vector(16'hFF00, 16'h0001, 16'h7FFF);
    send_vector(16'h0100, 16'h0000, 16'h0000);
    drain();

    send_idle_pct = 10;
    recv_idle_pct = 84;
    random_phase(450);

    // long receiver hold so the pipeline fills and backs up the input
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      random_phase(150);
    join
    drain();

    send_idle_pct = 84;
    recv_idle_pct = 10;
    random_phase(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(700);
    pause_sender();

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS vector3_normalize_unit");
    end else begin
      $display("FAIL vector3_normalize_unit");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL vector3_normalize_unit");
    $finish;
  end

endmodule
